FILE: rtl/ccc_pkg.sv
`timescale 1ns / 1ps
// shared types for the c source character classifier
// no dependencies; used by the lexer core, the top level and the testbench
package ccc_pkg;

  typedef enum logic [3:0] {
    M_NONE   = 4'd0,
    M_LINE   = 4'd1,
    M_BLOCK  = 4'd2,
    M_DEFINE = 4'd3,
    M_SQUOTE = 4'd4,
    M_DQUOTE = 4'd5,
    M_NUM    = 4'd6,
    M_HEX    = 4'd7,
    M_FRAC   = 4'd8,
    M_EXP    = 4'd9,
    M_SUF_U  = 4'd10,
    M_SUF_UL = 4'd11
  } lex_mode_t;

  typedef enum logic [2:0] {
    S_PLAIN    = 3'd0,
    S_COMMENT  = 3'd1,
    S_DEFINE   = 3'd2,
    S_CONST    = 3'd3,
    S_CONTROL  = 3'd4,
    S_VARTYPE  = 3'd5,
    S_NONASCII = 3'd6
  } style_t;

  localparam logic [2:0] STYLE_MAX = 3'd6;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] next_char;
    logic [1:0] chars_left;
    logic       first_in_line;
    logic       restart;
  } char_item_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic [7:0] prev_char;
    logic       esc;
    style_t     pend;
  } lex_state_t;

endpackage

FILE: rtl/ccc_char_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one source character beat with its lookahead
// no dependencies
interface ccc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [7:0] next_char;
  logic [1:0] chars_left;
  logic       first_in_line;
  logic       restart;

  modport source (output valid, char_code, next_char, chars_left, first_in_line, restart,
                  input ready);
  modport sink (input valid, char_code, next_char, chars_left, first_in_line, restart,
                output ready);
endinterface

FILE: rtl/ccc_style_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one style code beat
// no dependencies
interface ccc_style_if;
  logic       valid;
  logic       ready;
  logic [2:0] style_code;

  modport source (output valid, style_code, input ready);
  modport sink (input valid, style_code, output ready);
endinterface

FILE: rtl/ccc_lexer.sv
`timescale 1ns / 1ps
// lexer step: classifies one character and gives the next lexer state
// depends on ccc_pkg (state, item and style types)
module ccc_lexer (
  input  ccc_pkg::lex_state_t st,
  input  ccc_pkg::char_item_t item,
  output ccc_pkg::lex_state_t st_next,
  output ccc_pkg::style_t     style
);

  function automatic logic dig(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic xdig(input logic [7:0] ch);
    return dig(ch) || (ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F");
  endfunction

  function automatic logic ident(input logic [7:0] ch);
    return dig(ch) || (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  endfunction

  logic [7:0]          c, nx, p;
  logic                first, two;
  ccc_pkg::lex_mode_t  m;
  logic                esc;
  ccc_pkg::style_t     pend;

  // plain-mode classification
  ccc_pkg::lex_mode_t  pl_mode;
  ccc_pkg::style_t     pl_style, pl_pend;
  logic                pl_esc_clr;

  // mode-specific classification
  ccc_pkg::lex_mode_t  md_mode;
  ccc_pkg::style_t     md_style, md_pend;
  logic                md_esc, use_plain, esc_b;
  logic [7:0]          q;

  assign c     = item.char_code;
  assign nx    = item.next_char;
  assign first = item.first_in_line;
  assign two   = item.chars_left != 2'd0;
  assign p     = first ? 8'd0 : st.prev_char;

  // restart and line-start adjustments
  always_comb begin
    m    = item.restart ? ccc_pkg::M_NONE : st.mode;
    esc  = item.restart ? 1'b0 : st.esc;
    pend = item.restart ? ccc_pkg::S_PLAIN : st.pend;
    if (first) begin
      pend = ccc_pkg::S_PLAIN;
      if (m != ccc_pkg::M_BLOCK && m != ccc_pkg::M_SQUOTE && m != ccc_pkg::M_DQUOTE) begin
        m = ccc_pkg::M_NONE;
      end
    end
  end

  always_comb begin
    pl_mode    = ccc_pkg::M_NONE;
    pl_pend    = ccc_pkg::S_PLAIN;
    pl_esc_clr = 1'b0;
    priority if (two && c == "/" && nx == "/") begin
      pl_mode  = ccc_pkg::M_LINE;
      pl_style = ccc_pkg::S_COMMENT;
    end else if (two && c == "/" && nx == "*") begin
      pl_mode  = ccc_pkg::M_BLOCK;
      pl_style = ccc_pkg::S_COMMENT;
    end else if (c == "#") begin
      pl_mode  = ccc_pkg::M_DEFINE;
      pl_style = ccc_pkg::S_DEFINE;
    end else if (c == "'" || c == "\"") begin
      pl_mode    = (c == "\"") ? ccc_pkg::M_DQUOTE : ccc_pkg::M_SQUOTE;
      pl_esc_clr = 1'b1;
      pl_style   = ccc_pkg::S_CONST;
    end else if (!first && !ident(st.prev_char) && dig(c)) begin
      pl_mode  = ccc_pkg::M_NUM;
      pl_style = ccc_pkg::S_CONST;
      if (c == "0" && item.chars_left >= 2'd2 && nx == "x") begin
        pl_mode = ccc_pkg::M_HEX;
        pl_pend = ccc_pkg::S_CONST;
      end
    end else if (two && ((c == ":" && nx == ":") || (c == "-" && nx == ">"))) begin
      pl_pend  = ccc_pkg::S_VARTYPE;
      pl_style = ccc_pkg::S_VARTYPE;
    end else if (two && ((c == "=" && nx == "=") || (c == "&" && nx == "&") ||
                         (c == "|" && nx == "|") ||
                         ((c == "|" || c == "&" || c == "!" || c == "+" || c == "-") &&
                          nx == "="))) begin
      pl_pend  = ccc_pkg::S_CONTROL;
      pl_style = ccc_pkg::S_CONTROL;
    end else if (c == "&" || c == "." || c == "*" || c == "[" || c == "]") begin
      pl_style = ccc_pkg::S_VARTYPE;
    end else if (c == "~" || c == "=" || c == "^" || c == ":" || c == "%" || c == "+" ||
                 c == "-" || c == "<" || c == ">" || c == "!" || c == "?" || c == "(" ||
                 c == ")" || c == "{" || c == "}" || c == "," || c == ";" || c == "/" ||
                 c == "|") begin
      pl_style = ccc_pkg::S_CONTROL;
    end else if (c < 8'd32 || c > 8'd126) begin
      pl_style = ccc_pkg::S_NONASCII;
    end else begin
      pl_style = ccc_pkg::S_PLAIN;
    end
  end

  always_comb begin
    md_mode   = m;
    md_style  = ccc_pkg::S_CONST;
    md_pend   = ccc_pkg::S_PLAIN;
    md_esc    = esc;
    use_plain = 1'b0;
    q         = (m == ccc_pkg::M_DQUOTE) ? 8'("\"") : 8'("'");
    esc_b     = first ? 1'b0 : esc;
    unique case (m)
      ccc_pkg::M_LINE: begin
        md_style = ccc_pkg::S_COMMENT;
      end
      ccc_pkg::M_BLOCK: begin
        md_style = ccc_pkg::S_COMMENT;
        if (!first && p == "*" && c == "/") md_mode = ccc_pkg::M_NONE;
      end
      ccc_pkg::M_DEFINE: begin
        if (two && c == "/" && nx == "/") begin
          md_mode  = ccc_pkg::M_LINE;
          md_style = ccc_pkg::S_COMMENT;
        end else if (two && c == "/" && nx == "*") begin
          md_mode  = ccc_pkg::M_BLOCK;
          md_style = ccc_pkg::S_COMMENT;
        end else begin
          md_style = ccc_pkg::S_DEFINE;
        end
      end
      ccc_pkg::M_SQUOTE, ccc_pkg::M_DQUOTE: begin
        if (c == q && (p != "\\" || esc_b)) begin
          md_mode = ccc_pkg::M_NONE;
          md_esc  = 1'b0;
        end else begin
          md_esc = (p == "\\" && c == "\\") ? !esc_b : 1'b0;
        end
      end
      ccc_pkg::M_NUM: begin
        priority if (c == ".") begin
          md_mode = ccc_pkg::M_FRAC;
        end else if (c == "e" || c == "E") begin
          md_mode = ccc_pkg::M_EXP;
          if (two && (nx == "+" || nx == "-")) md_pend = ccc_pkg::S_CONST;
        end else if (dig(c)) begin
          md_style = ccc_pkg::S_CONST;
        end else if (c == "L" || c == "F") begin
          md_mode  = ccc_pkg::M_NONE;
          md_style = ccc_pkg::S_VARTYPE;
        end else if (c == "U") begin
          md_mode  = ccc_pkg::M_SUF_U;
          md_style = ccc_pkg::S_VARTYPE;
        end else begin
          use_plain = 1'b1;
        end
      end
      ccc_pkg::M_HEX: begin
        use_plain = !xdig(c);
      end
      ccc_pkg::M_FRAC: begin
        priority if (dig(c)) begin
          md_style = ccc_pkg::S_CONST;
        end else if (c == "e" || c == "E") begin
          md_mode = ccc_pkg::M_EXP;
          if (two && (nx == "+" || nx == "-")) md_pend = ccc_pkg::S_CONST;
        end else begin
          use_plain = 1'b1;
        end
      end
      ccc_pkg::M_EXP: begin
        use_plain = !dig(c);
      end
      ccc_pkg::M_SUF_U: begin
        if (c == "L") begin
          md_mode  = ccc_pkg::M_SUF_UL;
          md_style = ccc_pkg::S_VARTYPE;
        end else begin
          use_plain = 1'b1;
        end
      end
      ccc_pkg::M_SUF_UL: begin
        if (c == "L") begin
          md_mode  = ccc_pkg::M_NONE;
          md_style = ccc_pkg::S_VARTYPE;
        end else begin
          use_plain = 1'b1;
        end
      end
      default: begin
        use_plain = 1'b1;
      end
    endcase
  end

  // a pending second-character style wins over classification
  always_comb begin
    st_next.prev_char = c;
    if (pend != ccc_pkg::S_PLAIN) begin
      style        = pend;
      st_next.mode = m;
      st_next.esc  = esc;
      st_next.pend = ccc_pkg::S_PLAIN;
    end else if (use_plain) begin
      style        = pl_style;
      st_next.mode = pl_mode;
      st_next.esc  = pl_esc_clr ? 1'b0 : esc;
      st_next.pend = pl_pend;
    end else begin
      style        = md_style;
      st_next.mode = md_mode;
      st_next.esc  = md_esc;
      st_next.pend = md_pend;
    end
  end

endmodule

FILE: rtl/c_source_char_classifier.sv
`timescale 1ns / 1ps
// top level of the c source character classifier: input register, lexer state, result register
// depends on ccc_pkg, ccc_char_if, ccc_style_if and ccc_lexer
//
// usage
// - chars: one beat per source character, with the next character on the same
//   line, a saturating count of characters left on the line, a column-zero
//   flag and a restart flag that drops back to plain mode
// - styles: one beat per character carrying its 3-bit style code, in order
// - path: a character is loaded into the input register when it is accepted, and its
//   style is registered in the result register when the character leaves the input register
// - throughput: one character per cycle while styles is not stalled; the lexer state
//   loop runs from the state register through ccc_lexer and back into the state register
// - stall: while styles is stalled the result register holds, the input
//   register still takes one more beat, and chars.ready drops only when both
//   registers are full
// - reset (rst, synchronous): lexer in plain mode, previous character zero,
//   no escape and no pending style; both registers empty
module c_source_char_classifier (
  input logic          clk,
  input logic          rst,
  ccc_char_if.sink     chars,
  ccc_style_if.source  styles
);

  // input register
  logic                in_valid;
  ccc_pkg::char_item_t in_item;

  // lexer state
  ccc_pkg::lex_state_t st, st_next;
  ccc_pkg::style_t     style;

  // result register
  logic                out_valid;
  logic [2:0]          out_style;

  logic                advance;

  // the result register can take a new style when empty or being drained
  assign advance     = !out_valid || styles.ready;
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_item.char_code     <= chars.char_code;
      in_item.next_char     <= chars.next_char;
      in_item.chars_left    <= chars.chars_left;
      in_item.first_in_line <= chars.first_in_line;
      in_item.restart       <= chars.restart;
    end
  end

  ccc_lexer u_lexer (
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .style   (style)
  );

  // state moves only when a character leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode      <= ccc_pkg::M_NONE;
      st.prev_char <= 8'd0;
      st.esc       <= 1'b0;
      st.pend      <= ccc_pkg::S_PLAIN;
    end else if (in_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_style <= style;
    end
  end

  assign styles.valid      = out_valid;
  assign styles.style_code = out_style;

  // no style code beyond the defined range is ever sent
  a_style_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_style <= ccc_pkg::STYLE_MAX)
    else $error("style code out of range");

  // with both registers full and the output stalled, no new beat is taken
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !styles.ready) |-> !chars.ready)
    else $error("input taken while pipeline full");

  // lexer state is frozen while the result register is stalled
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !styles.ready) |=> $stable(st))
    else $error("lexer state moved during stall");

  // a stalled result holds its code
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !styles.ready) |=> (out_valid && $stable(out_style)))
    else $error("stalled style changed");

endmodule

FILE: bench/c_source_char_classifier_test.sv
`timescale 1ns / 1ps
// self-checking testbench for c_source_char_classifier: directed table, then random c-like lines
// depends on ccc_pkg, ccc_char_if, ccc_style_if and the classifier rtl
module c_source_char_classifier_test;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int MAX_IDLE      = 19;
  localparam int DRAIN_CYCLES  = 24;
  localparam int RUN_LIMIT_NS  = 5_000_000;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // one row of the directed table; typed rows carry a hand-written style
  typedef struct {
    ccc_pkg::char_item_t item;
    bit                  typed;
    ccc_pkg::style_t     style;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ccc_char_if  chars_bus ();
  ccc_style_if styles_bus ();

  c_source_char_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .styles (styles_bus)
  );

  always #5 clk = ~clk;

  // lexer state mirrored by the predictor
  ccc_pkg::lex_mode_t lex_mode;
  logic [7:0]         last_char;
  logic               in_escape;
  ccc_pkg::style_t    held_style;   // style owed to the second char of a two-char token

  ccc_pkg::style_t styles_due[$];  // styles of accepted chars, oldest first
  int              mismatches;
  int              styles_seen;
  bit              send_calm;      // stretches where a side never idles
  bit              take_calm;
  stim_row_t       directed_chars [DIRECTED_ROWS];

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // exponent start: a sign right after e/E gets the constant style too
  function automatic ccc_pkg::style_t begin_exponent(logic [7:0] nx, logic [1:0] left);
    lex_mode = ccc_pkg::M_EXP;
    if (left >= 2'd1 && (nx == "+" || nx == "-")) held_style = ccc_pkg::S_CONST;
    return ccc_pkg::S_CONST;
  endfunction

  // style of one accepted char; advances the mirrored lexer state
  function automatic ccc_pkg::style_t predict_style(ccc_pkg::char_item_t it);
    logic [7:0]      c, nx, p, quote;
    logic [1:0]      left;
    logic            first, two, esc, resolved;
    ccc_pkg::style_t style;
    c     = it.char_code;
    nx    = it.next_char;
    left  = it.chars_left;
    first = it.first_in_line;
    two   = left >= 2'd1;
    style = ccc_pkg::S_CONST;
    resolved = 1'b1;

    // restart drops everything back to plain
    if (it.restart) begin
      lex_mode   = ccc_pkg::M_NONE;
      in_escape  = 1'b0;
      held_style = ccc_pkg::S_PLAIN;
    end
    // a new line ends everything but block comments and quotes
    if (first) begin
      held_style = ccc_pkg::S_PLAIN;
      if (lex_mode != ccc_pkg::M_BLOCK && lex_mode != ccc_pkg::M_SQUOTE &&
          lex_mode != ccc_pkg::M_DQUOTE)
        lex_mode = ccc_pkg::M_NONE;
    end

    if (held_style != ccc_pkg::S_PLAIN) begin
      style      = held_style;
      held_style = ccc_pkg::S_PLAIN;
    end else begin
      p = first ? 8'h00 : last_char;
      case (lex_mode)
        ccc_pkg::M_LINE: style = ccc_pkg::S_COMMENT;
        ccc_pkg::M_BLOCK: begin
          // closes on a slash right after a star on the same line
          if (!first && p == "*" && c == "/") lex_mode = ccc_pkg::M_NONE;
          style = ccc_pkg::S_COMMENT;
        end
        ccc_pkg::M_DEFINE: begin
          if (two && c == "/" && nx == "/") begin
            lex_mode = ccc_pkg::M_LINE;
            style    = ccc_pkg::S_COMMENT;
          end else if (two && c == "/" && nx == "*") begin
            lex_mode = ccc_pkg::M_BLOCK;
            style    = ccc_pkg::S_COMMENT;
          end else begin
            style = ccc_pkg::S_DEFINE;
          end
        end
        ccc_pkg::M_SQUOTE, ccc_pkg::M_DQUOTE: begin
          quote = (lex_mode == ccc_pkg::M_DQUOTE) ? "\"" : "'";
          esc   = first ? 1'b0 : in_escape;
          if (c == quote && (p != "\\" || esc)) begin
            lex_mode  = ccc_pkg::M_NONE;
            in_escape = 1'b0;
          end else begin
            in_escape = (p == "\\" && c == "\\") ? !esc : 1'b0;
          end
          style = ccc_pkg::S_CONST;
        end
        ccc_pkg::M_NUM: begin
          if (c == ".") begin
            lex_mode = ccc_pkg::M_FRAC;
          end else if (c == "e" || c == "E") begin
            style = begin_exponent(nx, left);
          end else if (is_digit(c)) begin
            style = ccc_pkg::S_CONST;
          end else if (c == "L" || c == "F") begin
            lex_mode = ccc_pkg::M_NONE;
            style    = ccc_pkg::S_VARTYPE;
          end else if (c == "U") begin
            lex_mode = ccc_pkg::M_SUF_U;
            style    = ccc_pkg::S_VARTYPE;
          end else begin
            resolved = 1'b0;
          end
        end
        ccc_pkg::M_HEX:
          resolved = is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        ccc_pkg::M_FRAC: begin
          if (c == "e" || c == "E") style = begin_exponent(nx, left);
          else resolved = is_digit(c);
        end
        ccc_pkg::M_EXP: resolved = is_digit(c);
        ccc_pkg::M_SUF_U: begin
          if (c == "L") begin
            lex_mode = ccc_pkg::M_SUF_UL;
            style    = ccc_pkg::S_VARTYPE;
          end else begin
            resolved = 1'b0;
          end
        end
        ccc_pkg::M_SUF_UL: begin
          if (c == "L") begin
            lex_mode = ccc_pkg::M_NONE;
            style    = ccc_pkg::S_VARTYPE;
          end else begin
            resolved = 1'b0;
          end
        end
        default: resolved = 1'b0;
      endcase

      // anything that did not continue the current mode is looked at from plain
      if (!resolved) begin
        lex_mode = ccc_pkg::M_NONE;
        if (two && c == "/" && nx == "/") begin
          lex_mode = ccc_pkg::M_LINE;
          style    = ccc_pkg::S_COMMENT;
        end else if (two && c == "/" && nx == "*") begin
          lex_mode = ccc_pkg::M_BLOCK;
          style    = ccc_pkg::S_COMMENT;
        end else if (c == "#") begin
          lex_mode = ccc_pkg::M_DEFINE;
          style    = ccc_pkg::S_DEFINE;
        end else if (c == "'" || c == "\"") begin
          lex_mode  = (c == "\"") ? ccc_pkg::M_DQUOTE : ccc_pkg::M_SQUOTE;
          in_escape = 1'b0;
          style     = ccc_pkg::S_CONST;
        end else if (!first && is_digit(c) &&
                     !(is_digit(last_char) || (last_char >= "a" && last_char <= "z") ||
                       (last_char >= "A" && last_char <= "Z") || last_char == "_")) begin
          lex_mode = ccc_pkg::M_NUM;
          if (c == "0" && left >= 2'd2 && nx == "x") begin
            lex_mode   = ccc_pkg::M_HEX;
            held_style = ccc_pkg::S_CONST;
          end
          style = ccc_pkg::S_CONST;
        end else if (two && ((c == ":" && nx == ":") || (c == "-" && nx == ">"))) begin
          held_style = ccc_pkg::S_VARTYPE;
          style      = ccc_pkg::S_VARTYPE;
        end else if (two && ((c == "=" && nx == "=") || (c == "&" && nx == "&") ||
                             (c == "|" && nx == "|") ||
                             ((c == "|" || c == "&" || c == "!" || c == "+" || c == "-") &&
                              nx == "="))) begin
          held_style = ccc_pkg::S_CONTROL;
          style      = ccc_pkg::S_CONTROL;
        end else begin
          case (c)
            "&", ".", "*", "[", "]": style = ccc_pkg::S_VARTYPE;
            "~", "=", "^", ":", "%", "+", "-", "<", ">", "!", "?", "(", ")", "{", "}",
            ",", ";", "/", "|": style = ccc_pkg::S_CONTROL;
            default: style = (c < PRINT_LO || c > PRINT_HI) ? ccc_pkg::S_NONASCII
                                                             : ccc_pkg::S_PLAIN;
          endcase
        end
      end
    end

    last_char = c;
    return style;
  endfunction

  function automatic ccc_pkg::char_item_t char_beat(logic [7:0] c, logic [7:0] nx,
                                                    logic [1:0] left, logic first, logic rs);
    ccc_pkg::char_item_t b;
    b.char_code     = c;
    b.next_char     = nx;
    b.chars_left    = left;
    b.first_in_line = first;
    b.restart       = rs;
    return b;
  endfunction

  // pieces of c-like text that random lines are glued from
  function automatic string snippet(int k);
    string r;
    r = " ";
    case (k)
      0:  r = "int ";
      1:  r = "x";
      2:  r = " ";
      3:  r = "  ";
      4:  r = "0x1F";
      5:  r = "0xab";
      6:  r = "12.5e-3";
      7:  r = "3.0E+2";
      8:  r = "42UL";
      9:  r = "7ULL";
      10: r = "3L";
      11: r = "2.5F";
      12: r = "9U";
      13: r = "1e5";
      14: r = "// note";
      15: r = "/*";
      16: r = "*/";
      17: r = "*";
      18: r = "#define N ";
      19: r = "#include <a.h> /* x";
      20: r = "'a'";
      21: r = "'\\''";
      22: r = "\"s\\\"t\"";
      23: r = "\"";
      24: r = "'";
      25: r = "\\";
      26: r = "\\\\";
      27: r = "::";
      28: r = "->";
      29: r = "==";
      30: r = "&&";
      31: r = "||";
      32: r = "!=";
      33: r = "+=";
      34: r = "-=";
      35: r = "|=";
      36: r = "&=";
      37: r = "&.[]";
      38: r = "(){};,";
      39: r = "?:%~^<>|";
      40: r = "_v2";
      41: r = "\t";
      42: r = "/";
      43: r = "0x";
      44: r = "e+";
      45: r = ".5";
      46: r[0] = 8'("0" + $urandom_range(0, 9));
      default: r[0] = 8'($urandom_range(1, 255));
    endcase
    return r;
  endfunction

  function automatic int idle_cycles(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // offer one char beat, hold it until the block takes it, then log its style
  task automatic send_char(ccc_pkg::char_item_t it, bit typed, ccc_pkg::style_t typed_style);
    int              gap;
    ccc_pkg::style_t predicted;
    gap = idle_cycles(send_calm);
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      chars_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_bus.valid         <= 1'b1;
    chars_bus.char_code     <= it.char_code;
    chars_bus.next_char     <= it.next_char;
    chars_bus.chars_left    <= it.chars_left;
    chars_bus.first_in_line <= it.first_in_line;
    chars_bus.restart       <= it.restart;
    @(posedge clk);
    while (chars_bus.ready !== 1'b1) @(posedge clk);
    // taken at this edge: the predictor steps in the same order as the block
    predicted = predict_style(it);
    styles_due.push_back(typed ? typed_style : predicted);
  endtask

  // style side: random back-pressure, each taken beat checked against the oldest due style
  task automatic take_styles();
    int              stall;
    ccc_pkg::style_t want;
    forever begin
      stall = idle_cycles(take_calm);
      if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
      if (stall > 0) begin
        styles_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      styles_bus.ready <= 1'b1;
      @(posedge clk);
      while (styles_bus.valid !== 1'b1) @(posedge clk);
      if (styles_due.size() == 0) begin
        report_mismatch($sformatf("style beat %0d = %0d with no char waiting",
                                  styles_seen, styles_bus.style_code));
      end else begin
        want = styles_due.pop_front();
        if (styles_bus.style_code !== want)
          report_mismatch($sformatf("style beat %0d: got %0d, want %0d (%s)",
                                    styles_seen, styles_bus.style_code, want, want.name()));
      end
      styles_seen++;
    end
  endtask

  initial begin
    ccc_pkg::char_item_t beat;
    logic [7:0]          line_chars[$];
    string               s;
    int                  sent_random;
    int                  rest;

    // every input known from time zero
    rst                     <= 1'b1;
    chars_bus.valid         <= 1'b0;
    chars_bus.char_code     <= 8'h00;
    chars_bus.next_char     <= 8'h00;
    chars_bus.chars_left    <= 2'd0;
    chars_bus.first_in_line <= 1'b0;
    chars_bus.restart       <= 1'b0;
    styles_bus.ready        <= 1'b0;
    lex_mode    = ccc_pkg::M_NONE;
    last_char   = 8'h00;
    in_escape   = 1'b0;
    held_style  = ccc_pkg::S_PLAIN;
    mismatches  = 0;
    styles_seen = 0;
    send_calm   = 1'b0;
    take_calm   = 1'b0;

    // directed walk; styles are typed in only where obvious at a glance
    // byte extremes straight after reset, restart and line start together
    directed_chars[0]  = '{char_beat(8'h00, 8'hFF, 2'd3, 1'b1, 1'b1), 1'b1, ccc_pkg::S_NONASCII};
    directed_chars[1]  = '{char_beat(8'hFF, 8'h00, 2'd0, 1'b0, 1'b0), 1'b1, ccc_pkg::S_NONASCII};
    // #-line whose comment opens a block; slash-star-slash then closes it
    directed_chars[2]  = '{char_beat("#", "/", 2'd3, 1'b1, 1'b0), 1'b1, ccc_pkg::S_DEFINE};
    directed_chars[3]  = '{char_beat("/", "*", 2'd2, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[4]  = '{char_beat("*", "/", 2'd1, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[5]  = '{char_beat("/", 8'h00, 2'd0, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // digit at column zero is not a number
    directed_chars[6]  = '{char_beat("5", " ", 2'd3, 1'b1, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[7]  = '{char_beat(" ", "0", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // hex constant, ended by a two-char operator
    directed_chars[8]  = '{char_beat("0", "x", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[9]  = '{char_beat("x", "F", 2'd2, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[10] = '{char_beat("F", "+", 2'd1, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[11] = '{char_beat("+", "=", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[12] = '{char_beat("=", "1", 2'd2, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // decimal with the full unsigned long long suffix
    directed_chars[13] = '{char_beat("1", "U", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[14] = '{char_beat("U", "L", 2'd2, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[15] = '{char_beat("L", "L", 2'd1, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[16] = '{char_beat("L", ":", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // scope and arrow tokens; restart and a new line drop the owed style
    directed_chars[17] = '{char_beat(":", ":", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[18] = '{char_beat("-", ">", 2'd2, 1'b0, 1'b1), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[19] = '{char_beat(">", "\"", 2'd1, 1'b1, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // string with an escaped quote, running on into the next line
    directed_chars[20] = '{char_beat("\"", "\\", 2'd3, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[21] = '{char_beat("\\", "\"", 2'd2, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[22] = '{char_beat("\"", 8'h00, 2'd0, 1'b0, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    directed_chars[23] = '{char_beat("\"", "x", 2'd3, 1'b1, 1'b0), 1'b0, ccc_pkg::S_PLAIN};
    // line comment opened on a restart
    directed_chars[24] = '{char_beat("/", "/", 2'd3, 1'b0, 1'b1), 1'b0, ccc_pkg::S_PLAIN};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    fork
      take_styles();
    join_none

    foreach (directed_chars[k])
      send_char(directed_chars[k].item, directed_chars[k].typed, directed_chars[k].style);

    // random part: mostly whole c-like lines, with bursts of unrelated beats in between
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          beat.char_code     = 8'($urandom_range(0, 255));
          beat.next_char     = 8'($urandom_range(0, 255));
          beat.chars_left    = 2'($urandom_range(0, 3));
          beat.first_in_line = 1'($urandom_range(0, 1));
          beat.restart       = 1'($urandom_range(0, 1));
          send_char(beat, 1'b0, ccc_pkg::S_PLAIN);
          sent_random++;
        end
      end else begin
        line_chars.delete();
        repeat ($urandom_range(1, 8)) begin
          s = snippet($urandom_range(0, 47));
          for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
        end
        // lookahead, chars left and column flag follow from the line itself
        for (int i = 0; i < line_chars.size(); i++) begin
          rest = line_chars.size() - 1 - i;
          beat.char_code     = line_chars[i];
          beat.next_char     = (rest > 0) ? line_chars[i + 1] : 8'h00;
          beat.chars_left    = (rest > 3) ? 2'd3 : rest[1:0];
          beat.first_in_line = (i == 0);
          beat.restart       = ($urandom_range(0, 49) == 0);
          send_char(beat, 1'b0, ccc_pkg::S_PLAIN);
          sent_random++;
        end
      end
    end
    chars_bus.valid <= 1'b0;

    // let every due style come out, then watch a little longer for strays
    while (styles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #RUN_LIMIT_NS;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ccc_pkg.sv
rtl/ccc_char_if.sv
rtl/ccc_style_if.sv
rtl/ccc_lexer.sv
rtl/c_source_char_classifier.sv
bench/c_source_char_classifier_test.sv
